// ===== hw/rtl/rps_pkg.sv =====
// Shared types and constants for the relative path sanitizer.
package rps_pkg;

   localparam int BUF_BYTES_DEFAULT = 1024;
   localparam int CAP_W             = 11;
   localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_DOT   = 8'h2E;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_DENIED  = 2'd1,
      STATUS_TOOLONG = 2'd2
   } status_type;

   // Up to four words produced by one input byte, oldest in data[0].
   typedef struct packed {
      logic [3:0][7:0] data;
      logic [2:0]      cnt;
      logic            last;
      status_type      status;
   } bundle_type;

endpackage

// ===== hw/rtl/relative_path_sanitizer.sv =====
// Relative path sanitizer: top level with input register and capacity register.
// An accepted byte is held in the input register, then its result words in the result register.
// Throughput: one byte per cycle while rsp_ready is high and each byte yields at
// most one word; a byte that yields more words (up to four, after held dots)
// holds the input register while the result register drains one word per cycle.
// Reset: synchronous, clears path state and both valid flags; capacity reads 1024.
module relative_path_sanitizer #(
   parameter int BUF_BYTES = rps_pkg::BUF_BYTES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_ch,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_out_ch,
   output logic                      rsp_last,
   output logic [1:0]                rsp_status,
   input  logic                      csr_wr_en,
   input  logic [rps_pkg::CAP_W-1:0] csr_wr_data
);

   logic                      in_vld_ff, in_vld_in;
   logic [7:0]                in_ch_ff,  in_ch_in;
   logic [rps_pkg::CAP_W-1:0] cap_ff;
   logic                      emit_free;
   logic                      step_en;
   logic                      accept;
   rps_pkg::bundle_type       bundle;

   assign step_en   = in_vld_ff && emit_free;
   assign req_ready = !in_vld_ff || step_en;
   assign accept    = req_valid && req_ready;

   always_comb begin
      in_vld_in = in_vld_ff;
      in_ch_in  = in_ch_ff;
      if (accept) begin
         in_vld_in = 1'b1;
         in_ch_in  = req_ch;
      end else if (step_en) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         cap_ff    <= rps_pkg::CAP_RESET;
      end else begin
         in_vld_ff <= in_vld_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
      in_ch_ff <= in_ch_in;
   end

   rps_step #(
      .BUF_BYTES (BUF_BYTES)
   ) u_step (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step_en),
      .ch           (in_ch_ff),
      .out_capacity (cap_ff),
      .bundle       (bundle)
   );

   rps_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (step_en),
      .bundle     (bundle),
      .free       (emit_free),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_out_ch (rsp_out_ch),
      .rsp_last   (rsp_last),
      .rsp_status (rsp_status)
   );

endmodule

// ===== hw/rtl/rps_step.sv =====
// Path state and per-byte normalization logic.
module rps_step #(
   parameter int BUF_BYTES = rps_pkg::BUF_BYTES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  logic [7:0]               ch,
   input  logic [rps_pkg::CAP_W-1:0] out_capacity,
   output rps_pkg::bundle_type      bundle
);

   localparam int CW   = $clog2(BUF_BYTES);
   localparam int CMPW = ((CW > rps_pkg::CAP_W) ? CW : rps_pkg::CAP_W) + 1;
   localparam logic [CW-1:0] KEPT_MAX = CW'(BUF_BYTES - 1);

   typedef enum logic [1:0] {
      SEG_NONE     = 2'd0,
      SEG_ONE_DOT  = 2'd1,
      SEG_TWO_DOTS = 2'd2,
      SEG_NAME     = 2'd3
   } seg_type;

   logic          seen_any_ff,   seen_any_in;
   logic          prev_slash_ff, prev_slash_in;
   logic [CW-1:0] kept_count_ff, kept_count_in;
   seg_type       seg_len_ff,    seg_len_in;
   logic          dots_held_ff,  dots_held_in;
   logic [CW-1:0] out_len_ff,    out_len_in;
   logic          denied_ff,     denied_in;

   always_comb begin
      logic       is_sep;
      logic       denied_v;
      logic       too_long;
      logic       zero_cap;
      logic       emit;
      logic       open_seg;
      logic [1:0] ndots;
      logic [2:0] pos;

      seen_any_in   = seen_any_ff;
      prev_slash_in = prev_slash_ff;
      kept_count_in = kept_count_ff;
      seg_len_in    = seg_len_ff;
      dots_held_in  = dots_held_ff;
      out_len_in    = out_len_ff;
      denied_in     = denied_ff;

      bundle.data   = '0;
      bundle.cnt    = 3'd0;
      bundle.last   = 1'b0;
      bundle.status = rps_pkg::STATUS_OK;

      is_sep   = (ch == rps_pkg::CH_SLASH) || (ch == rps_pkg::CH_BSL);
      denied_v = denied_ff;
      too_long = (CMPW'(out_len_ff) + CMPW'(1)) > CMPW'(out_capacity);
      zero_cap = (out_capacity == '0);
      emit     = 1'b0;
      open_seg = 1'b0;
      ndots    = 2'd0;
      pos      = 3'd0;

      if (ch == rps_pkg::CH_NUL) begin
         if (dots_held_ff && seg_len_ff == SEG_TWO_DOTS) begin
            denied_v = 1'b1;
         end
         bundle.cnt  = 3'd1;
         bundle.last = 1'b1;
         priority if (too_long && zero_cap) begin
            bundle.status = rps_pkg::STATUS_TOOLONG;
         end else if (denied_v) begin
            bundle.status = rps_pkg::STATUS_DENIED;
         end else if (too_long) begin
            bundle.status = rps_pkg::STATUS_TOOLONG;
         end else begin
            bundle.status = rps_pkg::STATUS_OK;
         end
         // clear for the next path
         seen_any_in   = 1'b0;
         prev_slash_in = 1'b0;
         kept_count_in = '0;
         seg_len_in    = SEG_NONE;
         dots_held_in  = 1'b0;
         out_len_in    = '0;
         denied_in     = 1'b0;
      end else begin
         if (ch == rps_pkg::CH_COLON) begin
            denied_v = 1'b1;
         end
         if (!seen_any_ff && is_sep) begin
            denied_v = 1'b1;
         end
         seen_any_in = 1'b1;

         // drop bytes past the limit and repeated separators
         if (kept_count_ff != KEPT_MAX &&
             !(is_sep && prev_slash_ff && kept_count_ff != '0)) begin
            kept_count_in = kept_count_ff + CW'(1);
            prev_slash_in = is_sep;
            if (is_sep) begin
               if (dots_held_ff && seg_len_ff == SEG_TWO_DOTS) begin
                  denied_v = 1'b1;
               end
               seg_len_in   = SEG_NONE;
               dots_held_in = 1'b0;
            end else if (seg_len_ff == SEG_NONE) begin
               if (ch == rps_pkg::CH_DOT) begin
                  seg_len_in   = SEG_ONE_DOT;
                  dots_held_in = 1'b1;
               end else begin
                  emit       = 1'b1;
                  open_seg   = 1'b1;
                  seg_len_in = SEG_NAME;
               end
            end else if (dots_held_ff) begin
               if (ch == rps_pkg::CH_DOT && seg_len_ff == SEG_ONE_DOT) begin
                  seg_len_in = SEG_TWO_DOTS;
               end else begin
                  emit         = 1'b1;
                  open_seg     = 1'b1;
                  ndots        = seg_len_ff;
                  seg_len_in   = SEG_NAME;
                  dots_held_in = 1'b0;
               end
            end else begin
               emit = 1'b1;
            end
         end

         if (emit) begin
            if (open_seg && out_len_ff != '0) begin
               bundle.data[pos[1:0]] = rps_pkg::CH_SLASH;
               pos = pos + 3'd1;
            end
            for (int k = 0; k < 2; k++) begin
               if (2'(k) < ndots) begin
                  bundle.data[pos[1:0]] = rps_pkg::CH_DOT;
                  pos = pos + 3'd1;
               end
            end
            bundle.data[pos[1:0]] = ch;
            bundle.cnt = pos + 3'd1;
            out_len_in = out_len_ff + CW'(bundle.cnt);
         end
         denied_in = denied_v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_any_ff   <= 1'b0;
         prev_slash_ff <= 1'b0;
         kept_count_ff <= '0;
         seg_len_ff    <= SEG_NONE;
         dots_held_ff  <= 1'b0;
         out_len_ff    <= '0;
         denied_ff     <= 1'b0;
      end else if (step_en) begin
         seen_any_ff   <= seen_any_in;
         prev_slash_ff <= prev_slash_in;
         kept_count_ff <= kept_count_in;
         seg_len_ff    <= seg_len_in;
         dots_held_ff  <= dots_held_in;
         out_len_ff    <= out_len_in;
         denied_ff     <= denied_in;
      end
   end

endmodule

// ===== hw/rtl/rps_emit.sv =====
// Result register that hands out a burst of up to four words one at a time.
module rps_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  rps_pkg::bundle_type bundle,
   output logic                free,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_ch,
   output logic                rsp_last,
   output logic [1:0]          rsp_status
);

   logic [3:0][7:0]     data_ff,   data_in;
   logic [2:0]          cnt_ff,    cnt_in;
   logic                last_ff,   last_in;
   rps_pkg::status_type status_ff, status_in;
   logic                pop;

   assign pop  = (cnt_ff != 3'd0) && rsp_ready;
   assign free = (cnt_ff == 3'd0) || (cnt_ff == 3'd1 && rsp_ready);

   always_comb begin
      data_in   = data_ff;
      cnt_in    = cnt_ff;
      last_in   = last_ff;
      status_in = status_ff;
      if (load) begin
         data_in   = bundle.data;
         cnt_in    = bundle.cnt;
         last_in   = bundle.last;
         status_in = bundle.status;
      end else if (pop) begin
         // advance to the next word of the burst
         data_in = {8'h00, data_ff[3:1]};
         cnt_in  = cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      data_ff   <= data_in;
      last_ff   <= last_in;
      status_ff <= status_in;
   end

   assign rsp_valid  = (cnt_ff != 3'd0);
   assign rsp_out_ch = data_ff[0];
   assign rsp_last   = last_ff;
   assign rsp_status = status_ff;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the relative path sanitizer: directed table, then random paths.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BUF   = rps_pkg::BUF_BYTES_DEFAULT;
   localparam int CAP_W = rps_pkg::CAP_W;

   typedef struct {
      logic [7:0]          ch;
      logic                last;
      rps_pkg::status_type status;
   } word_type;

   typedef struct {
      logic [7:0]          ch;
      logic                typed;
      rps_pkg::status_type status;
   } row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [7:0]       req_ch = rps_pkg::CH_NUL;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [7:0]       rsp_out_ch;
   logic             rsp_last;
   logic [1:0]       rsp_status;
   logic             csr_wr_en = 1'b0;
   logic [CAP_W-1:0] csr_wr_data = '0;

   // predictor state for the path in flight
   logic [CAP_W-1:0] cap = rps_pkg::CAP_RESET;
   logic             seen_any = 1'b0;
   logic             prev_sep = 1'b0;
   logic             held_dots = 1'b0;
   logic             denied = 1'b0;
   logic [1:0]       seg_len = 2'd0;
   int unsigned      kept = 0;
   int unsigned      out_len = 0;

   word_type         pending_words[$];
   word_type         head;
   int               errors = 0;
   int               bytes_sent = 0;
   logic             steady = 1'b0;

   // directed paths; the status is typed in where it is plain from the path
   row_type directed_rows [24] = '{
      '{rps_pkg::CH_NUL,   1'b1, rps_pkg::STATUS_OK},       // empty path
      '{rps_pkg::CH_BSL,   1'b0, rps_pkg::STATUS_OK},
      '{"q",               1'b0, rps_pkg::STATUS_OK},
      '{rps_pkg::CH_NUL,   1'b1, rps_pkg::STATUS_DENIED},   // leading separator
      '{"a",               1'b0, rps_pkg::STATUS_OK},
      '{rps_pkg::CH_COLON, 1'b0, rps_pkg::STATUS_OK},
      '{rps_pkg::CH_NUL,   1'b1, rps_pkg::STATUS_DENIED},   // colon
      '{rps_pkg::CH_DOT,   1'b0, rps_pkg::STATUS_OK},
      '{rps_pkg::CH_DOT,   1'b0, rps_pkg::STATUS_OK},
      '{rps_pkg::CH_NUL,   1'b1, rps_pkg::STATUS_DENIED},   // trailing double dot
      '{rps_pkg::CH_DOT,   1'b0, rps_pkg::STATUS_OK},
      '{rps_pkg::CH_SLASH, 1'b0, rps_pkg::STATUS_OK},
      '{"b",               1'b0, rps_pkg::STATUS_OK},
      '{rps_pkg::CH_SLASH, 1'b0, rps_pkg::STATUS_OK},
      '{rps_pkg::CH_SLASH, 1'b0, rps_pkg::STATUS_OK},
      '{rps_pkg::CH_DOT,   1'b0, rps_pkg::STATUS_OK},
      '{rps_pkg::CH_DOT,   1'b0, rps_pkg::STATUS_OK},
      '{"x",               1'b0, rps_pkg::STATUS_OK},       // four-word burst
      '{rps_pkg::CH_BSL,   1'b0, rps_pkg::STATUS_OK},
      '{8'hFF,             1'b0, rps_pkg::STATUS_OK},
      '{8'h01,             1'b0, rps_pkg::STATUS_OK},
      '{rps_pkg::CH_DOT,   1'b0, rps_pkg::STATUS_OK},
      '{"y",               1'b0, rps_pkg::STATUS_OK},
      '{rps_pkg::CH_NUL,   1'b1, rps_pkg::STATUS_OK}
   };

   relative_path_sanitizer #(.BUF_BYTES(BUF)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_ch      (req_ch),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_out_ch  (rsp_out_ch),
      .rsp_last    (rsp_last),
      .rsp_status  (rsp_status),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   function automatic void clear_path();
      seen_any = 1'b0;
      prev_sep = 1'b0;
      held_dots = 1'b0;
      denied = 1'b0;
      seg_len = 2'd0;
      kept = 0;
      out_len = 0;
   endfunction

   function automatic void emit(input logic [7:0] b);
      pending_words.push_back('{ch: b, last: 1'b0, status: rps_pkg::STATUS_OK});
      out_len++;
   endfunction

   function automatic void normalize_byte(input logic [7:0] b);
      logic                sep;
      rps_pkg::status_type st;
      if (b == rps_pkg::CH_NUL) begin
         if (held_dots && seg_len == 2'd2) denied = 1'b1;
         if (cap == 0) st = rps_pkg::STATUS_TOOLONG;
         else if (denied) st = rps_pkg::STATUS_DENIED;
         else if (out_len + 1 > cap) st = rps_pkg::STATUS_TOOLONG;
         else st = rps_pkg::STATUS_OK;
         pending_words.push_back('{ch: rps_pkg::CH_NUL, last: 1'b1, status: st});
         clear_path();
         return;
      end
      sep = (b == rps_pkg::CH_SLASH) || (b == rps_pkg::CH_BSL);
      if (b == rps_pkg::CH_COLON) denied = 1'b1;
      if (!seen_any && sep) denied = 1'b1;
      seen_any = 1'b1;
      // past the buffer limit only colons matter
      if (kept + 1 >= BUF) return;
      if (sep && prev_sep && kept > 0) return;
      kept++;
      prev_sep = sep;
      if (sep) begin
         if (held_dots && seg_len == 2'd2) denied = 1'b1;
         seg_len = 2'd0;
         held_dots = 1'b0;
         return;
      end
      if (seg_len == 2'd0) begin
         if (b == rps_pkg::CH_DOT) begin
            seg_len = 2'd1;
            held_dots = 1'b1;
         end else begin
            if (out_len > 0) emit(rps_pkg::CH_SLASH);
            emit(b);
            seg_len = 2'd3;
         end
      end else if (held_dots) begin
         if (b == rps_pkg::CH_DOT && seg_len == 2'd1) begin
            seg_len = 2'd2;
         end else begin
            // release the held dots in front of the name
            if (out_len > 0) emit(rps_pkg::CH_SLASH);
            for (int k = 0; k < seg_len; k++) emit(rps_pkg::CH_DOT);
            emit(b);
            seg_len = 2'd3;
            held_dots = 1'b0;
         end
      end else begin
         emit(b);
      end
   endfunction

   function automatic logic [7:0] name_char();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255));
      while (c == rps_pkg::CH_SLASH || c == rps_pkg::CH_BSL || c == rps_pkg::CH_COLON);
      return c;
   endfunction

   function automatic logic [7:0] pick_sep();
      return $urandom_range(1) ? rps_pkg::CH_SLASH : rps_pkg::CH_BSL;
   endfunction

   task automatic send_byte(input logic [7:0] b);
      while (!steady && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch    <= b;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      normalize_byte(b);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] v);
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cap = v;
   endtask

   task automatic send_random_path();
      logic [7:0] path[$];
      int         segs;
      if ($urandom_range(9) == 0) path.push_back(pick_sep());
      segs = $urandom_range(4);
      for (int s = 0; s < segs; s++) begin
         case ($urandom_range(9))
            0: ;
            1: path.push_back(rps_pkg::CH_DOT);
            2: begin
               path.push_back(rps_pkg::CH_DOT);
               path.push_back(rps_pkg::CH_DOT);
            end
            3: begin
               repeat ($urandom_range(1, 3)) path.push_back(rps_pkg::CH_DOT);
               path.push_back(name_char());
            end
            default: repeat ($urandom_range(1, 5)) path.push_back(name_char());
         endcase
         if (s < segs - 1 || $urandom_range(3) == 0)
            repeat ($urandom_range(1, 2)) path.push_back(pick_sep());
      end
      if ($urandom_range(11) == 0)
         path.insert($urandom_range(path.size()), rps_pkg::CH_COLON);
      // occasional raw noise byte
      if (path.size() > 0 && $urandom_range(9) == 0)
         path[$urandom_range(path.size() - 1)] = 8'($urandom_range(1, 255));
      path.push_back(rps_pkg::CH_NUL);
      foreach (path[i]) send_byte(path[i]);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            errors++;
            $display("%0t: unexpected word ch=%h last=%b status=%0d", $time,
                     rsp_out_ch, rsp_last, rsp_status);
         end else begin
            head = pending_words.pop_front();
            if (rsp_out_ch !== head.ch) begin
               errors++;
               $display("%0t: out_ch expected %h got %h", $time, head.ch, rsp_out_ch);
            end
            if (rsp_last !== head.last) begin
               errors++;
               $display("%0t: last expected %b got %b", $time, head.last, rsp_last);
            end
            if (rsp_status !== head.status) begin
               errors++;
               $display("%0t: status expected %0d got %0d", $time, head.status, rsp_status);
            end
         end
      end
      rsp_ready <= steady || ($urandom_range(99) >= 7);
   end

   initial begin
      logic [CAP_W-1:0] caps [5];
      int               target;
      caps = '{11'd0, 11'd1, 11'd2047, CAP_W'($urandom_range(2, 12)), rps_pkg::CAP_RESET};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         send_byte(directed_rows[i].ch);
         if (directed_rows[i].typed)
            pending_words[pending_words.size() - 1] =
               '{ch: rps_pkg::CH_NUL, last: 1'b1, status: directed_rows[i].status};
      end
      foreach (caps[p]) begin
         write_capacity(caps[p]);
         // run the last block with no idling on either side
         if (p == 4) steady <= 1'b1;
         target = bytes_sent + 14;
         while (bytes_sent < target) send_random_path();
      end
      steady    <= 1'b0;
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/rps_pkg.sv
hw/rtl/rps_step.sv
hw/rtl/rps_emit.sv
hw/rtl/relative_path_sanitizer.sv
verif/tb_top.sv
